// ----- design/billboard_matrix_builder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Billboard matrix builder assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_MATRIX_BUILDER_CORE_MACROS_SVH
`define BILLBOARD_MATRIX_BUILDER_CORE_MACROS_SVH

// Check a property outside reset
`define BMB_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define BMB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/bmb_pkg.sv -----
// ----------------------------------------------------------------------------
// Billboard matrix builder package
// Widths, payload types, codes and saturation helper.
// ----------------------------------------------------------------------------
package bmb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = 32;
    localparam int LEAD_W    = $clog2(MAG_W);
    localparam int NM_W      = 30;
    localparam int SQ_W      = 2 * NM_W + 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int LOOK_W    = FRAC_BITS + 2;
    localparam int NUM_W     = ROOT_W + Q_W;
    localparam int PROD_W    = DATA_W + LOOK_W;
    localparam int E3_W      = 17;
    localparam int ADDR_W    = 5;

    localparam logic [LEAD_W-1:0] NORM_POS = LEAD_W'(NM_W - 1);
    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [E3_W-1:0] ENTRY3_ONE = E3_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W:0] SAT_HI =
        {{(PROD_W - DATA_W + 2){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [PROD_W:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        MODE_POINT = 2'd0,
        MODE_X     = 2'd1,
        MODE_Y     = 2'd2,
        MODE_Z     = 2'd3
    } t_mode;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_LOOK  = 2'd2;
    localparam logic [1:0] ROW_POS   = 2'd3;

    localparam logic [2:0] REG_CAM_POS_X = 3'd0;
    localparam logic [2:0] REG_CAM_POS_Y = 3'd1;
    localparam logic [2:0] REG_CAM_POS_Z = 3'd2;
    localparam logic [2:0] REG_CAM_UP_X  = 3'd3;
    localparam logic [2:0] REG_CAM_UP_Y  = 3'd4;
    localparam logic [2:0] REG_CAM_UP_Z  = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] object_x;
        logic signed [DATA_W-1:0] object_y;
        logic signed [DATA_W-1:0] object_z;
        logic [1:0]               facing_mode;
    } t_in;

    typedef struct packed {
        logic [1:0]               row_index;
        logic signed [DATA_W-1:0] entry_0;
        logic signed [DATA_W-1:0] entry_1;
        logic signed [DATA_W-1:0] entry_2;
        logic [E3_W-1:0]          entry_3;
        logic                     degenerate;
        logic                     last_row;
    } t_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [LOOK_W-1:0] x;
        logic signed [LOOK_W-1:0] y;
        logic signed [LOOK_W-1:0] z;
    } t_look;

    typedef struct packed {
        t_vec       pos;
        logic [1:0] mode;
        logic [2:0] neg;
        logic       zero;
    } t_side;

    typedef struct packed {
        t_side side;
        t_look look;
        t_vec  right;
    } t_carry;

    // Floor shift by the fraction width, then clamp to signed 32 bits
    function automatic logic signed [DATA_W-1:0] sat_shift(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] s;
        s = v >>> FRAC_BITS;
        if (s > SAT_HI) begin
            return SAT_HI[DATA_W-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[DATA_W-1:0];
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

// ----- design/bmb_front.sv -----
// ----------------------------------------------------------------------------
// bmb_front
// Look difference, magnitudes, normalising shift and sum of squares.
// ----------------------------------------------------------------------------
module bmb_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  bmb_pkg::t_in                         i_in,
    input  bmb_pkg::t_vec                        i_cam_pos,
    output logic                                 o_valid,
    output bmb_pkg::t_side                       o_side,
    output logic [2:0][bmb_pkg::NM_W-1:0]        o_nm,
    output logic [bmb_pkg::SQ_W-1:0]             o_sum
);

    logic signed [bmb_pkg::MAG_W:0] d [3];
    logic [2:0][bmb_pkg::MAG_W-1:0] mag;
    logic [2:0]                     neg;

    logic [4:0]                     r_valid;
    bmb_pkg::t_side                 r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [2:0][bmb_pkg::MAG_W-1:0] r1_mag, r2_mag;
    logic [bmb_pkg::LEAD_W-1:0]     r2_lead;
    logic [2:0][bmb_pkg::NM_W-1:0]  r3_nm, r4_nm, r5_nm;
    logic [2:0][2*bmb_pkg::NM_W-1:0] r4_sq;
    logic [bmb_pkg::SQ_W-1:0]       r5_sum;

    logic [bmb_pkg::MAG_W-1:0]      mx;
    logic [bmb_pkg::LEAD_W-1:0]     lead;
    logic [2:0][bmb_pkg::NM_W-1:0]  nm;
    bmb_pkg::t_side                 side_in, side2;

    // Difference towards the camera, axis component dropped
    always_comb begin
        d[0] = (bmb_pkg::MAG_W+1)'(i_cam_pos.x) - (bmb_pkg::MAG_W+1)'(i_in.object_x);
        d[1] = (bmb_pkg::MAG_W+1)'(i_cam_pos.y) - (bmb_pkg::MAG_W+1)'(i_in.object_y);
        d[2] = (bmb_pkg::MAG_W+1)'(i_cam_pos.z) - (bmb_pkg::MAG_W+1)'(i_in.object_z);
        case (i_in.facing_mode)
            bmb_pkg::MODE_X: d[0] = '0;
            bmb_pkg::MODE_Y: d[1] = '0;
            bmb_pkg::MODE_Z: d[2] = '0;
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            neg[i] = d[i][bmb_pkg::MAG_W];
            mag[i] = neg[i] ? bmb_pkg::MAG_W'(-d[i]) : bmb_pkg::MAG_W'(d[i]);
        end
        side_in.pos.x = i_in.object_x;
        side_in.pos.y = i_in.object_y;
        side_in.pos.z = i_in.object_z;
        side_in.mode  = i_in.facing_mode;
        side_in.neg   = neg;
        side_in.zero  = 1'b0;
    end

    // Leading one of the largest magnitude
    always_comb begin
        mx = r1_mag[0];
        if (r1_mag[1] > mx) mx = r1_mag[1];
        if (r1_mag[2] > mx) mx = r1_mag[2];
        lead = '0;
        for (int i = 0; i < bmb_pkg::MAG_W; i++) begin
            if (mx[i]) lead = bmb_pkg::LEAD_W'(i);
        end
        side2      = r1_side;
        side2.zero = (mx == '0);
    end

    // Bring the leading one to the normalised position
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_lead > bmb_pkg::NORM_POS) begin
                nm[i] = bmb_pkg::NM_W'(r2_mag[i] >> (r2_lead - bmb_pkg::NORM_POS));
            end else begin
                nm[i] = bmb_pkg::NM_W'(r2_mag[i] << (bmb_pkg::NORM_POS - r2_lead));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= side_in;
            r1_mag  <= mag;
            r2_side <= side2;
            r2_mag  <= r1_mag;
            r2_lead <= lead;
            r3_side <= r2_side;
            r3_nm   <= nm;
            r4_side <= r3_side;
            r4_nm   <= r3_nm;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= r3_nm[i] * r3_nm[i];
            end
            r5_side <= r4_side;
            r5_nm   <= r4_nm;
            r5_sum  <= bmb_pkg::SQ_W'(r4_sq[0]) + bmb_pkg::SQ_W'(r4_sq[1])
                     + bmb_pkg::SQ_W'(r4_sq[2]);
        end
    end

    assign o_valid = r_valid[4];
    assign o_side  = r5_side;
    assign o_nm    = r5_nm;
    assign o_sum   = r5_sum;

endmodule

// ----- design/bmb_isqrt.sv -----
// ----------------------------------------------------------------------------
// bmb_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bmb_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  bmb_pkg::t_side                   i_side,
    input  logic [2:0][bmb_pkg::NM_W-1:0]    i_nm,
    input  logic [bmb_pkg::SQ_W-1:0]         i_sum,
    output logic                             o_valid,
    output bmb_pkg::t_side                   o_side,
    output logic [2:0][bmb_pkg::NM_W-1:0]    o_nm,
    output logic [bmb_pkg::ROOT_W-1:0]       o_len
);

    localparam int TW = bmb_pkg::SQ_W + 2;

    logic                          r_valid [bmb_pkg::ROOT_W];
    bmb_pkg::t_side                r_side  [bmb_pkg::ROOT_W];
    logic [2:0][bmb_pkg::NM_W-1:0] r_nm    [bmb_pkg::ROOT_W];
    logic [bmb_pkg::SQ_W-1:0]      r_rem   [bmb_pkg::ROOT_W];
    logic [bmb_pkg::ROOT_W-1:0]    r_root  [bmb_pkg::ROOT_W];

    for (genvar k = 0; k < bmb_pkg::ROOT_W; k++) begin : g_stage
        localparam int B = bmb_pkg::ROOT_W - 1 - k;

        logic                          v_in;
        bmb_pkg::t_side                side_in;
        logic [2:0][bmb_pkg::NM_W-1:0] nm_in;
        logic [bmb_pkg::SQ_W-1:0]      rem_in;
        logic [bmb_pkg::ROOT_W-1:0]    root_in;
        logic [TW-1:0]                 trial;
        logic                          fits;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign nm_in   = i_nm;
            assign rem_in  = i_sum;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign side_in = r_side[k-1];
            assign nm_in   = r_nm[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // Trial subtrahend (2*root + bit) * bit
        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign fits  = (TW'(rem_in) >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                r_nm[k]   <= nm_in;
                r_rem[k]  <= fits ? bmb_pkg::SQ_W'(TW'(rem_in) - trial) : rem_in;
                r_root[k] <= fits ? (root_in | (bmb_pkg::ROOT_W'(1) << B)) : root_in;
            end
        end
    end

    assign o_valid = r_valid[bmb_pkg::ROOT_W-1];
    assign o_side  = r_side[bmb_pkg::ROOT_W-1];
    assign o_nm    = r_nm[bmb_pkg::ROOT_W-1];
    assign o_len   = r_root[bmb_pkg::ROOT_W-1];

endmodule

// ----- design/bmb_div.sv -----
// ----------------------------------------------------------------------------
// bmb_div
// Three-lane restoring divider forming the unit look vector.
// ----------------------------------------------------------------------------
module bmb_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  bmb_pkg::t_side                   i_side,
    input  logic [2:0][bmb_pkg::NM_W-1:0]    i_nm,
    input  logic [bmb_pkg::ROOT_W-1:0]       i_len,
    output logic                             o_valid,
    output bmb_pkg::t_side                   o_side,
    output bmb_pkg::t_look                   o_look
);

    localparam int NW = bmb_pkg::NUM_W;

    logic                          r_valid [bmb_pkg::Q_W];
    bmb_pkg::t_side                r_side  [bmb_pkg::Q_W];
    logic [bmb_pkg::ROOT_W-1:0]    r_len   [bmb_pkg::Q_W];
    logic [2:0][NW-1:0]            r_rem   [bmb_pkg::Q_W];
    logic [2:0][bmb_pkg::Q_W-1:0]  r_q     [bmb_pkg::Q_W];

    logic                          r_out_valid;
    bmb_pkg::t_side                r_out_side;
    bmb_pkg::t_look                r_look;

    for (genvar k = 0; k < bmb_pkg::Q_W; k++) begin : g_stage
        localparam int B = bmb_pkg::Q_W - 1 - k;

        logic                         v_in;
        bmb_pkg::t_side               side_in;
        logic [bmb_pkg::ROOT_W-1:0]   len_in;
        logic [2:0][NW-1:0]           rem_in;
        logic [2:0][bmb_pkg::Q_W-1:0] q_in;
        logic [NW-1:0]                dv;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign len_in  = i_len;
            assign q_in    = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                // Numerator with half the divisor added for rounding
                assign rem_in[l] = (NW'(i_nm[l]) << bmb_pkg::FRAC_BITS) + NW'(i_len >> 1);
            end
        end else begin : g_next
            assign v_in    = r_valid[k-1];
            assign side_in = r_side[k-1];
            assign len_in  = r_len[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
        end

        assign dv = NW'(len_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                r_len[k]  <= len_in;
                for (int l = 0; l < 3; l++) begin
                    if (rem_in[l] >= dv) begin
                        r_rem[k][l] <= rem_in[l] - dv;
                        r_q[k][l]   <= q_in[l] | (bmb_pkg::Q_W'(1) << B);
                    end else begin
                        r_rem[k][l] <= rem_in[l];
                        r_q[k][l]   <= q_in[l];
                    end
                end
            end
        end
    end

    // Clamp to one, restore sign, clear a zero-length look
    logic [2:0][bmb_pkg::Q_W-1:0]    qc;
    logic [2:0][bmb_pkg::LOOK_W-1:0] lv;
    bmb_pkg::t_side                  fs;

    always_comb begin
        fs = r_side[bmb_pkg::Q_W-1];
        for (int l = 0; l < 3; l++) begin
            qc[l] = (r_q[bmb_pkg::Q_W-1][l] > bmb_pkg::Q_ONE) ? bmb_pkg::Q_ONE
                                                             : r_q[bmb_pkg::Q_W-1][l];
            if (fs.zero) begin
                lv[l] = '0;
            end else if (fs.neg[l]) begin
                lv[l] = -bmb_pkg::LOOK_W'(qc[l]);
            end else begin
                lv[l] = bmb_pkg::LOOK_W'(qc[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[bmb_pkg::Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_side <= fs;
            r_look.x   <= lv[0];
            r_look.y   <= lv[1];
            r_look.z   <= lv[2];
        end
    end

    assign o_valid = r_out_valid;
    assign o_side  = r_out_side;
    assign o_look  = r_look;

endmodule

// ----- design/bmb_cross.sv -----
// ----------------------------------------------------------------------------
// bmb_cross
// Two-stage cross product of a word vector with the unit look vector.
// ----------------------------------------------------------------------------
module bmb_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  bmb_pkg::t_vec   i_a,
    input  bmb_pkg::t_look  i_b,
    input  bmb_pkg::t_carry i_carry,
    output logic            o_valid,
    output bmb_pkg::t_vec   o_r,
    output bmb_pkg::t_carry o_carry
);

    logic [1:0]                         r_valid;
    logic signed [bmb_pkg::PROD_W-1:0]  r_p [6];
    bmb_pkg::t_carry                    r1_carry, r2_carry;
    bmb_pkg::t_vec                      r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= i_a.y * i_b.z;
            r_p[1]   <= i_a.z * i_b.y;
            r_p[2]   <= i_a.z * i_b.x;
            r_p[3]   <= i_a.x * i_b.z;
            r_p[4]   <= i_a.x * i_b.y;
            r_p[5]   <= i_a.y * i_b.x;
            r1_carry <= i_carry;
            r2_carry <= r1_carry;
            r_res.x  <= bmb_pkg::sat_shift((bmb_pkg::PROD_W+1)'(r_p[0])
                                         - (bmb_pkg::PROD_W+1)'(r_p[1]));
            r_res.y  <= bmb_pkg::sat_shift((bmb_pkg::PROD_W+1)'(r_p[2])
                                         - (bmb_pkg::PROD_W+1)'(r_p[3]));
            r_res.z  <= bmb_pkg::sat_shift((bmb_pkg::PROD_W+1)'(r_p[4])
                                         - (bmb_pkg::PROD_W+1)'(r_p[5]));
        end
    end

    assign o_valid = r_valid[1];
    assign o_r     = r_res;
    assign o_carry = r2_carry;

endmodule

// ----- design/bmb_ser.sv -----
// ----------------------------------------------------------------------------
// bmb_ser
// Matrix holding register and row sequencer for the result channel.
// ----------------------------------------------------------------------------
`include "billboard_matrix_builder_core_macros.svh"

module bmb_ser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bmb_pkg::t_vec  i_right,
    input  bmb_pkg::t_vec  i_up,
    input  bmb_pkg::t_vec  i_look,
    input  bmb_pkg::t_vec  i_pos,
    input  logic           i_degen,
    input  logic           i_ready,
    output logic           o_take,
    output logic           o_valid,
    output bmb_pkg::t_out  o_out
);

    logic          r_busy;
    logic [1:0]    r_row;
    bmb_pkg::t_vec r_right, r_up, r_look, r_pos;
    logic          r_degen;
    bmb_pkg::t_vec sel;

    assign o_take = !r_busy || (i_ready && r_row == bmb_pkg::ROW_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= bmb_pkg::ROW_RIGHT;
        end else if (i_valid && o_take) begin
            r_busy <= 1'b1;
            r_row  <= bmb_pkg::ROW_RIGHT;
        end else if (r_busy && i_ready) begin
            if (r_row == bmb_pkg::ROW_POS) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_right <= i_right;
            r_up    <= i_up;
            r_look  <= i_look;
            r_pos   <= i_pos;
            r_degen <= i_degen;
        end
    end

    always_comb begin
        case (r_row)
            bmb_pkg::ROW_RIGHT: sel = r_right;
            bmb_pkg::ROW_UP:    sel = r_up;
            bmb_pkg::ROW_LOOK:  sel = r_look;
            default:            sel = r_pos;
        endcase
        o_out.row_index  = r_row;
        o_out.entry_0    = sel.x;
        o_out.entry_1    = sel.y;
        o_out.entry_2    = sel.z;
        o_out.entry_3    = (r_row == bmb_pkg::ROW_POS) ? bmb_pkg::ENTRY3_ONE : '0;
        o_out.degenerate = r_degen;
        o_out.last_row   = (r_row == bmb_pkg::ROW_POS);
    end

    assign o_valid = r_busy;

    `BMB_ASSERT_CLK(a_row_walk, r_busy && i_ready && r_row != bmb_pkg::ROW_POS |=> r_busy && r_row == $past(r_row) + 2'd1, "row sequence skipped a row")
    `BMB_ASSERT_CLK(a_hold_busy, r_busy && !i_ready |=> r_busy && $stable(r_row), "matrix dropped while stalled")
    `BMB_ASSERT_CLK(a_degen_look, r_busy && r_degen && r_row == bmb_pkg::ROW_LOOK |-> r_look == '0, "zero-length look not cleared")

endmodule

// ----- design/billboard_matrix_builder_core.sv -----
// ----------------------------------------------------------------------------
// Billboard matrix builder core
// Builds a 4x4 billboard matrix per object and streams it as four row beats.
// ----------------------------------------------------------------------------
// Path: front end, square root, divider, right and up cross products and
//   the output hold, in that order, before the first row beat is offered;
//   the stages before the hold stall together. Flow: a new matrix enters
//   the hold when none is held or as the last of the four row beats of the
//   one before is accepted; the input side takes a beat in any cycle the pipe moves.
// Reset: synchronous, active low; clears every valid bit, the row sequencer
//   and the camera registers (position zero, up vector along +y).
module billboard_matrix_builder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Object channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bmb_pkg::t_in                 i_in,
    // Row channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bmb_pkg::t_out                o_out,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Camera registers
    // ------------------------------------------------------------------
    bmb_pkg::t_vec r_cam_pos, r_cam_up;
    logic [2:0]    reg_idx;

    assign reg_idx = paddr[bmb_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos   <= '0;
            r_cam_up.x  <= '0;
            r_cam_up.y  <= bmb_pkg::ONE_Q;
            r_cam_up.z  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                bmb_pkg::REG_CAM_POS_X: r_cam_pos.x <= pwdata;
                bmb_pkg::REG_CAM_POS_Y: r_cam_pos.y <= pwdata;
                bmb_pkg::REG_CAM_POS_Z: r_cam_pos.z <= pwdata;
                bmb_pkg::REG_CAM_UP_X:  r_cam_up.x  <= pwdata;
                bmb_pkg::REG_CAM_UP_Y:  r_cam_up.y  <= pwdata;
                bmb_pkg::REG_CAM_UP_Z:  r_cam_up.z  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back, unmapped offsets read as zero
    always_comb begin
        unique case (reg_idx)
            bmb_pkg::REG_CAM_POS_X: prdata = r_cam_pos.x;
            bmb_pkg::REG_CAM_POS_Y: prdata = r_cam_pos.y;
            bmb_pkg::REG_CAM_POS_Z: prdata = r_cam_pos.z;
            bmb_pkg::REG_CAM_UP_X:  prdata = r_cam_up.x;
            bmb_pkg::REG_CAM_UP_Y:  prdata = r_cam_up.y;
            bmb_pkg::REG_CAM_UP_Z:  prdata = r_cam_up.z;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipe advance: every stage moves together; hold all of them while the
    // last stage has a matrix the row sequencer cannot yet take.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic ser_take;
    logic x2_valid;

    assign pipe_en    = ser_take || !x2_valid;
    assign o_in_ready = pipe_en;

    // Front end: difference, magnitudes, normalise, sum of squares
    logic                          f_valid;
    bmb_pkg::t_side                f_side;
    logic [2:0][bmb_pkg::NM_W-1:0] f_nm;
    logic [bmb_pkg::SQ_W-1:0]      f_sum;

    bmb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (i_in_valid),
        .i_in      (i_in),
        .i_cam_pos (r_cam_pos),
        .o_valid   (f_valid),
        .o_side    (f_side),
        .o_nm      (f_nm),
        .o_sum     (f_sum)
    );

    // Length of the normalised difference
    logic                          s_valid;
    bmb_pkg::t_side                s_side;
    logic [2:0][bmb_pkg::NM_W-1:0] s_nm;
    logic [bmb_pkg::ROOT_W-1:0]    s_len;

    bmb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_nm    (f_nm),
        .i_sum   (f_sum),
        .o_valid (s_valid),
        .o_side  (s_side),
        .o_nm    (s_nm),
        .o_len   (s_len)
    );

    // Unit look vector
    logic           d_valid;
    bmb_pkg::t_side d_side;
    bmb_pkg::t_look d_look;

    bmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (s_valid),
        .i_side  (s_side),
        .i_nm    (s_nm),
        .i_len   (s_len),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_look  (d_look)
    );

    // Unit axis for the axis modes; zero vector in point mode
    function automatic bmb_pkg::t_vec axis_vec(input logic [1:0] mode);
        bmb_pkg::t_vec v;
        v = '0;
        case (mode)
            bmb_pkg::MODE_X: v.x = bmb_pkg::ONE_Q;
            bmb_pkg::MODE_Y: v.y = bmb_pkg::ONE_Q;
            bmb_pkg::MODE_Z: v.z = bmb_pkg::ONE_Q;
            default: ;
        endcase
        return v;
    endfunction

    // Right: camera up (point mode) or the axis, crossed with look
    bmb_pkg::t_vec   x1_a;
    bmb_pkg::t_carry x1_carry_in, x1_carry;
    bmb_pkg::t_vec   x1_r;
    logic            x1_valid;

    always_comb begin
        x1_a = (d_side.mode == bmb_pkg::MODE_POINT) ? r_cam_up : axis_vec(d_side.mode);
        x1_carry_in.side  = d_side;
        x1_carry_in.look  = d_look;
        x1_carry_in.right = '0;
    end

    bmb_cross u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (d_valid),
        .i_a     (x1_a),
        .i_b     (d_look),
        .i_carry (x1_carry_in),
        .o_valid (x1_valid),
        .o_r     (x1_r),
        .o_carry (x1_carry)
    );

    // Up for point mode: right crossed with look
    bmb_pkg::t_carry x2_carry_in, x2_carry;
    bmb_pkg::t_vec   x2_r;

    always_comb begin
        x2_carry_in       = x1_carry;
        x2_carry_in.right = x1_r;
    end

    bmb_cross u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (x1_valid),
        .i_a     (x1_r),
        .i_b     (x1_carry.look),
        .i_carry (x2_carry_in),
        .o_valid (x2_valid),
        .o_r     (x2_r),
        .o_carry (x2_carry)
    );

    // ------------------------------------------------------------------
    // Assemble the matrix rows and hand them to the row sequencer
    // ------------------------------------------------------------------
    bmb_pkg::t_vec m_up, m_look;

    always_comb begin
        m_up = (x2_carry.side.mode == bmb_pkg::MODE_POINT) ? x2_r
                                                          : axis_vec(x2_carry.side.mode);
        // Widen the unit look to full words
        m_look.x = bmb_pkg::DATA_W'(x2_carry.look.x);
        m_look.y = bmb_pkg::DATA_W'(x2_carry.look.y);
        m_look.z = bmb_pkg::DATA_W'(x2_carry.look.z);
    end

    bmb_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x2_valid),
        .i_right (x2_carry.right),
        .i_up    (m_up),
        .i_look  (m_look),
        .i_pos   (x2_carry.side.pos),
        .i_degen (x2_carry.side.zero),
        .i_ready (i_out_ready),
        .o_take  (ser_take),
        .o_valid (o_out_valid),
        .o_out   (o_out)
    );

endmodule
